[rtl/core/lgge_pkg.sv]
// Shared constants, types and helpers of the life grid generation engine.
package lgge_pkg;

	localparam int GRID_H = 16;
	localparam int GRID_W = 16;
	localparam int ROW_W  = $clog2(GRID_H);
	localparam int STEP_W = $clog2(GRID_H + 3);

	localparam logic [1:0] OP_CLEAR   = 2'd0;
	localparam logic [1:0] OP_WRITE   = 2'd1;
	localparam logic [1:0] OP_READ    = 2'd2;
	localparam logic [1:0] OP_ADVANCE = 2'd3;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_WR_RD,
		ST_WR_WB,
		ST_RD_RD,
		ST_RD_OUT,
		ST_GEN
	} state_t;

	typedef struct packed {
		logic             capture;
		logic             rd_en;
		logic             wr_en;
		logic             rd_gen;
		logic             wr_gen;
		logic [ROW_W-1:0] gen_rd_addr;
		logic [ROW_W-1:0] gen_wr_addr;
		logic             valid_clear;
		logic             win_clear;
		logic             shift_en;
		logic             shift_zero;
		logic             load_out;
		logic             out_is_read;
	} cmd_t;

	function automatic logic [ROW_W-1:0] to_row(input logic [3:0] r);
		logic [ROW_W+3:0] t;
		t = {{ROW_W{1'b0}}, r};
		return t[ROW_W-1:0];
	endfunction

endpackage

[rtl/core/lgge_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module lgge_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[rtl/core/lgge_ctrl.sv]
// Controller state machine that sequences cell operations and generation sweeps.
module lgge_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic [1:0]    op,
	input  logic          out_stall,
	output logic          in_stall,
	output logic          out_valid,
	output lgge_pkg::cmd_t cmd
);

	localparam logic [lgge_pkg::STEP_W-1:0] STEP_LAST  =
		lgge_pkg::STEP_W'(lgge_pkg::GRID_H + 2);
	localparam logic [lgge_pkg::STEP_W-1:0] STEP_ZERO_IN =
		lgge_pkg::STEP_W'(lgge_pkg::GRID_H + 1);
	localparam logic [lgge_pkg::STEP_W-1:0] STEP_RD_END =
		lgge_pkg::STEP_W'(lgge_pkg::GRID_H);
	localparam logic [lgge_pkg::STEP_W-1:0] STEP_WR_BEGIN = lgge_pkg::STEP_W'(3);
	localparam logic [lgge_pkg::STEP_W-1:0] STEP_ONE = lgge_pkg::STEP_W'(1);

	lgge_pkg::state_t            state_q, state_d;
	logic [lgge_pkg::STEP_W-1:0] step_q;
	logic [lgge_pkg::STEP_W-1:0] wr_step;
	logic                        out_valid_q;
	logic                        accept;
	logic                        out_free;

	assign in_stall  = (state_q != lgge_pkg::ST_IDLE);
	assign accept    = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;
	assign wr_step   = step_q - STEP_WR_BEGIN;

	always_comb begin
		state_d = state_q;
		case (state_q)
			lgge_pkg::ST_IDLE: begin
				if (accept) begin
					case (op)
						lgge_pkg::OP_CLEAR: state_d = lgge_pkg::ST_CLEAR;
						lgge_pkg::OP_WRITE: state_d = lgge_pkg::ST_WR_RD;
						lgge_pkg::OP_READ:  state_d = lgge_pkg::ST_RD_RD;
						default:            state_d = lgge_pkg::ST_GEN;
					endcase
				end
			end
			lgge_pkg::ST_CLEAR:  if (out_free) state_d = lgge_pkg::ST_IDLE;
			lgge_pkg::ST_WR_RD:  state_d = lgge_pkg::ST_WR_WB;
			lgge_pkg::ST_WR_WB:  if (out_free) state_d = lgge_pkg::ST_IDLE;
			lgge_pkg::ST_RD_RD:  state_d = lgge_pkg::ST_RD_OUT;
			lgge_pkg::ST_RD_OUT: if (out_free) state_d = lgge_pkg::ST_IDLE;
			lgge_pkg::ST_GEN: begin
				if (step_q == STEP_LAST && out_free) begin
					state_d = lgge_pkg::ST_IDLE;
				end
			end
			default: state_d = lgge_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd             = '0;
		cmd.capture     = accept;
		cmd.gen_rd_addr = step_q[lgge_pkg::ROW_W-1:0];
		cmd.gen_wr_addr = wr_step[lgge_pkg::ROW_W-1:0];
		case (state_q)
			lgge_pkg::ST_CLEAR: begin
				cmd.valid_clear = out_free;
				cmd.load_out    = out_free;
			end
			lgge_pkg::ST_WR_RD: cmd.rd_en = 1'b1;
			lgge_pkg::ST_WR_WB: begin
				cmd.wr_en    = out_free;
				cmd.load_out = out_free;
			end
			lgge_pkg::ST_RD_RD: cmd.rd_en = 1'b1;
			lgge_pkg::ST_RD_OUT: begin
				cmd.load_out    = out_free;
				cmd.out_is_read = 1'b1;
			end
			lgge_pkg::ST_GEN: begin
				cmd.rd_gen     = 1'b1;
				cmd.wr_gen     = 1'b1;
				cmd.rd_en      = (step_q < STEP_RD_END);
				cmd.win_clear  = (step_q == '0);
				cmd.shift_en   = (step_q >= STEP_ONE) && (step_q <= STEP_ZERO_IN);
				cmd.shift_zero = (step_q == STEP_ZERO_IN);
				if (step_q == STEP_LAST) begin
					cmd.wr_en    = out_free;
					cmd.load_out = out_free;
				end else begin
					cmd.wr_en = (step_q >= STEP_WR_BEGIN);
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= lgge_pkg::ST_IDLE;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q != lgge_pkg::ST_GEN) begin
				step_q <= '0;
			end else if (step_q != STEP_LAST) begin
				step_q <= step_q + STEP_ONE;
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

[rtl/core/lgge_dp.sv]
// Datapath: grid RAM, row valid bits, three-row window, rule logic and result register.
module lgge_dp (
	input  logic                 clk,
	input  logic                 arst_n,
	input  lgge_pkg::cmd_t       cmd,
	input  logic [1:0]           op,
	input  logic [3:0]           cell_row,
	input  logic [3:0]           cell_col,
	input  logic                 cell_in,
	output logic                 cell_out,
	output logic [1:0]           op_done
);

	localparam int W = lgge_pkg::GRID_W;

	logic [1:0]                op_q;
	logic [3:0]                row_q;
	logic [3:0]                col_q;
	logic                      val_q;
	logic                      in_grid;
	logic [lgge_pkg::GRID_H-1:0] valid_q;
	logic                      rd_valid_s1;
	logic [lgge_pkg::ROW_W-1:0] rd_addr;
	logic [lgge_pkg::ROW_W-1:0] wr_addr;
	logic [W-1:0]              wr_data;
	logic                      wr_en;
	logic [W-1:0]              rdata;
	logic [W-1:0]              row_data;
	logic [W-1:0]              cell_row_new;
	logic                      bit_sel;
	logic [W-1:0]              win_prev_q;
	logic [W-1:0]              win_cur_q;
	logic [W-1:0]              win_next_q;
	logic [W-1:0]              gen_row;
	logic                      cell_out_q;
	logic [1:0]                op_done_q;

	assign in_grid = (int'(row_q) < lgge_pkg::GRID_H) && (int'(col_q) < W);
	assign rd_addr = cmd.rd_gen ? cmd.gen_rd_addr : lgge_pkg::to_row(row_q);
	assign wr_addr = cmd.wr_gen ? cmd.gen_wr_addr : lgge_pkg::to_row(row_q);
	assign wr_data = cmd.wr_gen ? gen_row : cell_row_new;
	assign wr_en   = cmd.wr_en && (cmd.wr_gen || in_grid);
	// A row that was never written since reset or clear reads as all dead.
	assign row_data = rd_valid_s1 ? rdata : '0;

	lgge_ram #(
		.WIDTH(W),
		.DEPTH(lgge_pkg::GRID_H)
	) u_grid (
		.clk  (clk),
		.we   (wr_en),
		.waddr(wr_addr),
		.wdata(wr_data),
		.re   (cmd.rd_en),
		.raddr(rd_addr),
		.rdata(rdata)
	);

	always_comb begin
		cell_row_new = row_data;
		bit_sel      = 1'b0;
		for (int i = 0; i < W; i++) begin
			if (int'(col_q) == i) begin
				cell_row_new[i] = val_q;
				bit_sel         = row_data[i];
			end
		end
	end

	// B3/S23 on the window: prev, cur and next are the old rows above, at and below.
	always_comb begin
		logic [3:0] cnt;
		gen_row = '0;
		for (int c = 0; c < W; c++) begin
			cnt = 4'd0;
			for (int dc = -1; dc <= 1; dc++) begin
				if (c + dc >= 0 && c + dc < W) begin
					cnt = cnt + 4'(win_prev_q[c+dc]) + 4'(win_next_q[c+dc]);
					if (dc != 0) begin
						cnt = cnt + 4'(win_cur_q[c+dc]);
					end
				end
			end
			gen_row[c] = (cnt == 4'd3) || (win_cur_q[c] && cnt == 4'd2);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (cmd.valid_clear) begin
			valid_q <= '0;
		end else if (wr_en) begin
			valid_q[wr_addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q  <= op;
			row_q <= cell_row;
			col_q <= cell_col;
			val_q <= cell_in;
		end
		if (cmd.rd_en) begin
			rd_valid_s1 <= valid_q[rd_addr];
		end
		if (cmd.win_clear) begin
			win_prev_q <= '0;
			win_cur_q  <= '0;
			win_next_q <= '0;
		end else if (cmd.shift_en) begin
			win_prev_q <= win_cur_q;
			win_cur_q  <= win_next_q;
			win_next_q <= cmd.shift_zero ? '0 : row_data;
		end
		if (cmd.load_out) begin
			cell_out_q <= cmd.out_is_read && in_grid && bit_sel;
			op_done_q  <= op_q;
		end
	end

	assign cell_out = cell_out_q;
	assign op_done  = op_done_q;

endmodule

[rtl/core/life_grid_generation_engine.sv]
// Top level of the life grid generation engine: a bounded B3/S23 cell grid.
//
// Input channel (in_valid, in_stall, op, cell_row, cell_col, cell_in) takes one
// item when in_valid is high and in_stall is low. Output channel (out_valid,
// out_stall, cell_out, op_done) presents exactly one result item per input item.
// Clear, a cell write and a cell read each end with the result in the output
// register. An advance sweeps the grid row by row through the single read port
// of the grid RAM. Only one item is worked on at a time; in_stall is high while
// it is in progress.
// The result sits in an output register. A new item is accepted while it waits;
// if out_stall is still high when the next result is ready, the block holds
// that result back and waits without losing or repeating work.
// Asynchronous reset marks every row as dead at once through per-row valid
// bits, so the block can take an item in the first cycle after reset.
module life_grid_generation_engine (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [1:0] op,
	input  logic [3:0] cell_row,
	input  logic [3:0] cell_col,
	input  logic       cell_in,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       cell_out,
	output logic [1:0] op_done
);

	lgge_pkg::cmd_t cmd;

	lgge_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.op       (op),
		.out_stall(out_stall),
		.in_stall (in_stall),
		.out_valid(out_valid),
		.cmd      (cmd)
	);

	lgge_dp u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.op      (op),
		.cell_row(cell_row),
		.cell_col(cell_col),
		.cell_in (cell_in),
		.cell_out(cell_out),
		.op_done (op_done)
	);

endmodule

[tb/life_grid_checker.sv]
// Checker for the life grid engine: predicts every result item and compares it.
module life_grid_checker
	import lgge_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_stall,
	input  logic [1:0] op,
	input  logic [3:0] cell_row,
	input  logic [3:0] cell_col,
	input  logic       cell_in,
	input  logic       out_valid,
	input  logic       out_stall,
	input  logic       cell_out,
	input  logic [1:0] op_done,
	output int         fail_count,
	output int         pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic       cell_out;
		logic [1:0] op_done;
	} life_result_t;

	// Current generation as this side sees it; the block resets to all dead.
	bit [GRID_W-1:0] life_grid [GRID_H];
	life_result_t results_due [$];

	initial begin
		foreach (life_grid[i])
			life_grid[i] = '0;
	end

	// One B3/S23 generation; cells beyond the border count as dead.
	function automatic void step_generation();
		bit [GRID_W-1:0] prev [GRID_H];
		int n;
		int rr;
		int cc;
		prev = life_grid;
		for (int r = 0; r < GRID_H; r++) begin
			for (int c = 0; c < GRID_W; c++) begin
				n = 0;
				for (int dr = -1; dr <= 1; dr++) begin
					for (int dc = -1; dc <= 1; dc++) begin
						rr = r + dr;
						cc = c + dc;
						if ((dr != 0 || dc != 0) && rr >= 0 && rr < GRID_H && cc >= 0 && cc < GRID_W)
							n += prev[rr][cc];
					end
				end
				life_grid[r][c] = prev[r][c] ? (n == 2 || n == 3) : (n == 3);
			end
		end
	endfunction

	function automatic life_result_t apply_item(input logic [1:0] code, input logic [3:0] r,
			input logic [3:0] c, input logic v);
		life_result_t res;
		bit on_grid;
		res.cell_out = 1'b0;
		res.op_done  = code;
		on_grid = (r < GRID_H) && (c < GRID_W);
		case (code)
			OP_CLEAR: begin
				foreach (life_grid[i])
					life_grid[i] = '0;
			end
			OP_WRITE: begin
				if (on_grid)
					life_grid[r][c] = v;
			end
			OP_READ: begin
				if (on_grid)
					res.cell_out = life_grid[r][c];
			end
			OP_ADVANCE: begin
				step_generation();
			end
		endcase
		return res;
	endfunction

	always @(posedge clk) begin : watch
		life_result_t got;
		life_result_t want;
		if (!arst_n) begin
			fail_count = 0;
			pending <= 0;
		end else begin
			// A result always trails its item by cycles, so retire before queueing.
			if (out_valid && !out_stall) begin
				got = '{cell_out, op_done};
				if (results_due.size() == 0) begin
					fail_count++;
					$display("%0t: result item with none expected: cell_out %0d op_done %0d",
						$time, cell_out, op_done);
				end else begin
					want = results_due.pop_front();
					if (got.cell_out !== want.cell_out) begin
						fail_count++;
						$display("%0t: cell_out expected %0d, got %0d", $time,
							want.cell_out, got.cell_out);
					end
					if (got.op_done !== want.op_done) begin
						fail_count++;
						$display("%0t: op_done expected %0d, got %0d", $time,
							want.op_done, got.op_done);
					end
				end
			end
			if (in_valid && !in_stall)
				results_due.push_back(apply_item(op, cell_row, cell_col, cell_in));
			pending <= results_due.size();
		end
	end

endmodule

[tb/testbench.sv]
// Top of the life grid engine testbench: clock, reset, stimulus and the verdict.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import lgge_pkg::*;

	localparam int ITEM_TARGET = 700;
	localparam int CALM_AFTER  = 600;
	localparam int QUIET_LIMIT = 2000;
	localparam int SETTLE      = 30;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [1:0] op = OP_CLEAR;
	logic [3:0] cell_row = '0;
	logic [3:0] cell_col = '0;
	logic       cell_in = 1'b0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic       cell_out;
	logic [1:0] op_done;

	int fail_count;
	int pending;
	int item_count = 0;
	int quiet_cycles = 0;
	bit gaps_on = 1'b1;
	bit stall_on = 1'b1;

	life_grid_generation_engine u_top (.*);

	life_grid_checker u_checker (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == QUIET_LIMIT) begin
			$display("simulation failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Receiver: stall bursts separated by random stretches of readiness.
	initial begin
		forever begin
			repeat ($urandom_range(1, 14)) @(posedge clk);
			if (stall_on) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 11)) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	task automatic send_item(input logic [1:0] code, input logic [3:0] r, input logic [3:0] c,
			input logic v);
		if (gaps_on && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		in_valid <= 1'b1;
		op       <= code;
		cell_row <= r;
		cell_col <= c;
		cell_in  <= v;
		do @(posedge clk); while (in_stall);
		item_count++;
	endtask

	// Holds the sender off until every outstanding result item has been taken.
	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	initial begin
		logic [3:0] pr;
		logic [3:0] pc;
		logic [3:0] rr;
		logic [3:0] cc;
		int span;
		int pick;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part: reset contents, corners, edge blinker, unused fields.
		send_item(OP_READ, 4'd0, 4'd0, 1'b1);
		send_item(OP_READ, 4'd15, 4'd15, 1'b0);
		send_item(OP_CLEAR, 4'd15, 4'd15, 1'b1);
		send_item(OP_WRITE, 4'd0, 4'd0, 1'b1);
		send_item(OP_WRITE, 4'd15, 4'd15, 1'b1);
		send_item(OP_WRITE, 4'd0, 4'd15, 1'b1);
		send_item(OP_WRITE, 4'd15, 4'd0, 1'b1);
		send_item(OP_READ, 4'd0, 4'd0, 1'b0);
		send_item(OP_READ, 4'd15, 4'd15, 1'b1);
		send_item(OP_READ, 4'd0, 4'd15, 1'b0);
		send_item(OP_READ, 4'd15, 4'd0, 1'b1);
		send_item(OP_ADVANCE, 4'd0, 4'd0, 1'b0);
		send_item(OP_READ, 4'd15, 4'd15, 1'b0);
		send_item(OP_WRITE, 4'd0, 4'd1, 1'b1);
		send_item(OP_WRITE, 4'd0, 4'd2, 1'b1);
		send_item(OP_WRITE, 4'd0, 4'd3, 1'b1);
		send_item(OP_ADVANCE, 4'd9, 4'd6, 1'b1);
		send_item(OP_READ, 4'd1, 4'd2, 1'b0);
		send_item(OP_READ, 4'd0, 4'd1, 1'b0);
		send_item(OP_READ, 4'd0, 4'd2, 1'b0);
		send_item(OP_WRITE, 4'd5, 4'd6, 1'b0);
		send_item(OP_ADVANCE, 4'd15, 4'd15, 1'b1);
		send_item(OP_CLEAR, 4'd0, 4'd0, 1'b0);
		send_item(OP_READ, 4'd7, 4'd9, 1'b0);
		drain();

		while (item_count < ITEM_TARGET) begin
			if (item_count >= CALM_AFTER) begin
				gaps_on  = 1'b0;
				stall_on = 1'b0;
			end else begin
				gaps_on  = ($urandom_range(0, 2) != 0);
				stall_on = ($urandom_range(0, 2) != 0);
			end
			pick = $urandom_range(0, 9);
			if (pick == 0) begin
				// Noise: any operation with any field values.
				repeat ($urandom_range(4, 8))
					send_item(2'($urandom_range(0, 3)), 4'($urandom_range(0, 15)),
						4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
			end else begin
				// Seed a patch, which may straddle the border, then let it evolve.
				if ($urandom_range(0, 2) == 0)
					send_item(OP_CLEAR, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
						1'($urandom_range(0, 1)));
				pr = 4'($urandom_range(0, 15));
				pc = 4'($urandom_range(0, 15));
				span = $urandom_range(3, 5);
				for (int i = 0; i < span; i++) begin
					for (int j = 0; j < span; j++) begin
						rr = pr + 4'(i);
						cc = pc + 4'(j);
						pick = $urandom_range(0, 99);
						if (pick < 40)
							send_item(OP_WRITE, rr, cc, 1'b1);
						else if (pick < 48)
							send_item(OP_WRITE, rr, cc, 1'b0);
					end
				end
				repeat ($urandom_range(1, 4)) begin
					send_item(OP_ADVANCE, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
						1'($urandom_range(0, 1)));
					repeat ($urandom_range(2, 6)) begin
						rr = pr + 4'($urandom_range(0, span + 1)) - 4'd1;
						cc = pc + 4'($urandom_range(0, span + 1)) - 4'd1;
						if ($urandom_range(0, 5) == 0) begin
							rr = 4'($urandom_range(0, 15));
							cc = 4'($urandom_range(0, 15));
						end
						send_item(OP_READ, rr, cc, 1'($urandom_range(0, 1)));
					end
				end
			end
			if (item_count < CALM_AFTER && $urandom_range(0, 7) == 0)
				drain();
		end

		drain();
		repeat (SETTLE) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

[sim.f]
rtl/core/lgge_pkg.sv
rtl/core/lgge_ram.sv
rtl/core/lgge_ctrl.sv
rtl/core/lgge_dp.sv
rtl/core/life_grid_generation_engine.sv
tb/life_grid_checker.sv
tb/testbench.sv
